>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SPTA_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("invariant check failed");

// consequent checked in the same cycle as the antecedent
`define SPTA_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle implication failed");

// consequent checked in the cycle after the antecedent
`define SPTA_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle implication failed");

`endif

>>> rtl/spta_pkg.sv
// shared types, codes and constants of the sparse polynomial term adder
`default_nettype none

package spta_pkg;

   localparam int DEFAULT_MAX_TERMS = 32;
   localparam int COEF_W            = 32;
   localparam int POWER_W           = 8;
   localparam int ENTRY_W           = COEF_W + 2 * POWER_W;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;
   localparam logic [1:0] REQ_EMIT  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_MERGED = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;

   typedef struct packed {
      logic [POWER_W-1:0] power_x;
      logic [POWER_W-1:0] power_y;
   } key_type;

   typedef struct packed {
      logic cmp_en;     // capture the match vector for the key
      logic key_we;     // store the key of a newly appended entry
      logic abs_set;    // mark an entry as having absorbed a term
      logic clear_all;  // drop every absorbed mark
   } match_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ADD_SEL = 4'b0010,
      ST_ADD_WR  = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/spta_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module spta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/spta_match.sv
// power keys, absorbed marks and first-match search over the term table
`default_nettype none

module spta_match #(
   parameter int MAX_TERMS = spta_pkg::DEFAULT_MAX_TERMS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire spta_pkg::match_ctl_type            ctl,
   input  wire spta_pkg::key_type                  key,
   input  wire logic [$clog2(MAX_TERMS)-1:0]       wr_idx,
   input  wire logic [$clog2(MAX_TERMS)-1:0]       set_idx,
   input  wire logic [$clog2(MAX_TERMS+1)-1:0]     first_count,
   output logic                                    hit,
   output logic      [$clog2(MAX_TERMS)-1:0]       hit_idx
);

   import spta_pkg::*;

   localparam int IW = $clog2(MAX_TERMS);
   localparam int CW = $clog2(MAX_TERMS + 1);

   key_type              key_ff [MAX_TERMS];
   key_type              key_in [MAX_TERMS];
   logic [MAX_TERMS-1:0] absorbed_ff;
   logic [MAX_TERMS-1:0] absorbed_in;
   logic [MAX_TERMS-1:0] match_ff;
   logic [MAX_TERMS-1:0] match_in;

   // one comparator per entry, limited to first-polynomial entries not yet absorbed
   always_comb begin
      for (int i = 0; i < MAX_TERMS; i++) begin
         match_in[i] = (CW'(i) < first_count) && !absorbed_ff[i] && (key_ff[i] == key);
         key_in[i]   = key_ff[i];
      end
      if (ctl.key_we) begin
         key_in[wr_idx] = key;
      end
   end

   always_comb begin
      absorbed_in = absorbed_ff;
      if (ctl.clear_all) begin
         absorbed_in = '0;
      end else begin
         if (ctl.key_we) begin
            absorbed_in[wr_idx] = 1'b0;
         end
         if (ctl.abs_set) begin
            absorbed_in[set_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         absorbed_ff <= '0;
      end else begin
         absorbed_ff <= absorbed_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (ctl.cmp_en) begin
         match_ff <= match_in;
      end
   end

   // lowest matching index wins
   always_comb begin
      hit     = |match_ff;
      hit_idx = '0;
      for (int i = MAX_TERMS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IW'(i);
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/sparse_poly_term_adder_core.sv
// top level of the sparse polynomial term adder: sequencer, term ram and key matcher
// load and clear answer in the cycle after start; add answers after key compare and select
//   on append or full, and after key compare, select and ram rmw on a merge
// emit of n terms: one term word per cycle from the registered ram read, busy while reading
// load, clear, empty emit keep busy low; add and emit hold it until done; busy gates start
// the receiver cannot stall: every rsp word is valid for exactly one cycle
// reset clears counts and absorbed marks at once; term contents stay undefined until written
`default_nettype none
`include "assert_macros.svh"

module sparse_poly_term_adder_core #(
   parameter int MAX_TERMS = spta_pkg::DEFAULT_MAX_TERMS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [1:0]                   req_type,
   input  wire logic signed [spta_pkg::COEF_W-1:0]  req_coefficient,
   input  wire logic        [spta_pkg::POWER_W-1:0] req_power_x,
   input  wire logic        [spta_pkg::POWER_W-1:0] req_power_y,
   // response channel
   output logic                                     rsp_valid,
   output logic signed      [spta_pkg::COEF_W-1:0]  rsp_out_coefficient,
   output logic             [spta_pkg::POWER_W-1:0] rsp_out_power_x,
   output logic             [spta_pkg::POWER_W-1:0] rsp_out_power_y,
   output logic                                     rsp_is_term,
   output logic                                     rsp_last,
   output logic             [1:0]                   rsp_status
);

   import spta_pkg::*;

   localparam int IW = $clog2(MAX_TERMS);
   localparam int CW = $clog2(MAX_TERMS + 1);

   // control registers
   state_type         state_ff, state_in;
   logic [CW-1:0]     term_count_ff, term_count_in;
   logic [CW-1:0]     first_count_ff, first_count_in;
   logic              ack_valid_ff, ack_valid_in;
   logic              emit_out_ff, emit_out_in;

   // payload registers
   logic [COEF_W-1:0]  coef_ff, coef_in;
   logic [POWER_W-1:0] px_ff, px_in;
   logic [POWER_W-1:0] py_ff, py_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in;
   logic [IW-1:0]      tgt_idx_ff, tgt_idx_in;
   logic [1:0]         ack_status_ff, ack_status_in;
   logic               emit_last_ff, emit_last_in;

   // ram ports
   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [COEF_W-1:0]  rd_coef;
   logic [POWER_W-1:0] rd_px;
   logic [POWER_W-1:0] rd_py;

   // matcher ports
   match_ctl_type      mctl;
   key_type            mkey;
   logic               hit;
   logic [IW-1:0]      hit_idx;

   logic               accept;
   logic               full;
   logic [CW-1:0]      count_m1;

   // terms for the checks
   logic               emit_final;
   logic               append_step;
   logic [CW-1:0]      count_p1;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign full     = (term_count_ff == CW'(MAX_TERMS));
   assign count_m1 = term_count_ff - CW'(1);

   assign {rd_coef, rd_px, rd_py} = ram_rdata;

   // compare and load use the request ports directly; later states use the latched word
   always_comb begin
      if (state_ff == ST_IDLE) begin
         mkey.power_x = req_power_x;
         mkey.power_y = req_power_y;
      end else begin
         mkey.power_x = px_ff;
         mkey.power_y = py_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      term_count_in  = term_count_ff;
      first_count_in = first_count_ff;
      ack_valid_in   = 1'b0;
      ack_status_in  = ack_status_ff;
      emit_out_in    = 1'b0;
      emit_last_in   = emit_last_ff;
      coef_in        = coef_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      rd_idx_in      = rd_idx_ff;
      tgt_idx_in     = tgt_idx_ff;
      ram_we         = 1'b0;
      ram_waddr      = term_count_ff[IW-1:0];
      ram_wdata      = {coef_ff, px_ff, py_ff};
      ram_raddr      = rd_idx_ff;
      mctl           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               coef_in = req_coefficient;
               px_in   = req_power_x;
               py_in   = req_power_y;
               case (req_type)
                  REQ_LOAD: begin
                     ack_valid_in = 1'b1;
                     if (full) begin
                        ack_status_in = STAT_FULL;
                     end else begin
                        ack_status_in  = STAT_OK;
                        ram_we         = 1'b1;
                        ram_wdata      = {req_coefficient, req_power_x, req_power_y};
                        mctl.key_we    = 1'b1;
                        term_count_in  = term_count_ff + CW'(1);
                        first_count_in = term_count_ff + CW'(1);
                     end
                  end
                  REQ_ADD: begin
                     mctl.cmp_en = 1'b1;
                     state_in    = ST_ADD_SEL;
                  end
                  REQ_EMIT: begin
                     if (term_count_ff == '0) begin
                        ack_valid_in  = 1'b1;
                        ack_status_in = STAT_OK;
                     end else begin
                        rd_idx_in = '0;
                        state_in  = ST_EMIT;
                     end
                  end
                  REQ_CLEAR: begin
                     ack_valid_in   = 1'b1;
                     ack_status_in  = STAT_OK;
                     term_count_in  = '0;
                     first_count_in = '0;
                     mctl.clear_all = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ADD_SEL: begin
            if (hit) begin
               // fetch the target coefficient for the read-modify-write
               ram_raddr  = hit_idx;
               tgt_idx_in = hit_idx;
               state_in   = ST_ADD_WR;
            end else begin
               ack_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (full) begin
                  ack_status_in = STAT_FULL;
               end else begin
                  // appended terms become merge targets only after a later load
                  ack_status_in = STAT_OK;
                  ram_we        = 1'b1;
                  mctl.key_we   = 1'b1;
                  term_count_in = term_count_ff + CW'(1);
               end
            end
         end
         ST_ADD_WR: begin
            ram_we        = 1'b1;
            ram_waddr     = tgt_idx_ff;
            ram_wdata     = {rd_coef + coef_ff, px_ff, py_ff};
            mctl.abs_set  = 1'b1;
            ack_valid_in  = 1'b1;
            ack_status_in = STAT_MERGED;
            state_in      = ST_IDLE;
         end
         ST_EMIT: begin
            // one ram read per cycle, data word shows the cycle after
            ram_raddr    = rd_idx_ff;
            emit_out_in  = 1'b1;
            emit_last_in = (CW'(rd_idx_ff) == count_m1);
            if (CW'(rd_idx_ff) == count_m1) begin
               state_in = ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         term_count_ff  <= '0;
         first_count_ff <= '0;
         ack_valid_ff   <= 1'b0;
         emit_out_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         term_count_ff  <= term_count_in;
         first_count_ff <= first_count_in;
         ack_valid_ff   <= ack_valid_in;
         emit_out_ff    <= emit_out_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff       <= coef_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      rd_idx_ff     <= rd_idx_in;
      tgt_idx_ff    <= tgt_idx_in;
      ack_status_ff <= ack_status_in;
      emit_last_ff  <= emit_last_in;
   end

   // term storage: coefficient and both powers per entry
   spta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TERMS)
   ) u_term_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // parallel key compare against all entries
   spta_match #(
      .MAX_TERMS (MAX_TERMS)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mctl),
      .key         (mkey),
      .wr_idx      (term_count_ff[IW-1:0]),
      .set_idx     (tgt_idx_ff),
      .first_count (first_count_ff),
      .hit         (hit),
      .hit_idx     (hit_idx)
   );

   // response word: emitted term straight from the ram read register, else the ack
   assign rsp_valid           = ack_valid_ff || emit_out_ff;
   assign rsp_out_coefficient = emit_out_ff ? rd_coef : '0;
   assign rsp_out_power_x     = emit_out_ff ? rd_px : '0;
   assign rsp_out_power_y     = emit_out_ff ? rd_py : '0;
   assign rsp_is_term         = emit_out_ff;
   assign rsp_last            = emit_out_ff ? emit_last_ff : 1'b1;
   assign rsp_status          = emit_out_ff ? STAT_OK : ack_status_ff;

   // checks
   assign emit_final  = (state_ff == ST_EMIT) && emit_last_in;
   assign append_step = (state_ff == ST_ADD_SEL) && !hit && !full;
   assign count_p1    = term_count_ff + CW'(1);

   `SPTA_ASSERT_ALWAYS(a_count_bound, clock, reset, term_count_ff <= CW'(MAX_TERMS))
   `SPTA_ASSERT_ALWAYS(a_first_le_count, clock, reset, first_count_ff <= term_count_ff)
   `SPTA_ASSERT_ALWAYS(a_single_source, clock, reset, !(ack_valid_ff && emit_out_ff))
   `SPTA_ASSERT_NXT(a_emit_end, clock, reset, emit_final, !busy && rsp_last && rsp_is_term)
   `SPTA_ASSERT_NXT(a_append_grows, clock, reset, append_step, term_count_ff == $past(count_p1))

endmodule

`default_nettype wire

>>> tb/term_table_checker.sv
// checker for the sparse polynomial term adder: predicts every response word and compares it
`timescale 1ns / 1ps

module term_table_checker #(
   parameter int MAX_TERMS = spta_pkg::DEFAULT_MAX_TERMS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic        [1:0]                   req_type,
   input  logic signed [spta_pkg::COEF_W-1:0]  req_coefficient,
   input  logic        [spta_pkg::POWER_W-1:0] req_power_x,
   input  logic        [spta_pkg::POWER_W-1:0] req_power_y,
   input  logic                                rsp_valid,
   input  logic signed [spta_pkg::COEF_W-1:0]  rsp_out_coefficient,
   input  logic        [spta_pkg::POWER_W-1:0] rsp_out_power_x,
   input  logic        [spta_pkg::POWER_W-1:0] rsp_out_power_y,
   input  logic                                rsp_is_term,
   input  logic                                rsp_last,
   input  logic        [1:0]                   rsp_status,
   output int                                  error_count,
   output int                                  words_outstanding
);

   import spta_pkg::*;

   typedef struct packed {
      logic signed [COEF_W-1:0]  coef;
      logic        [POWER_W-1:0] power_x;
      logic        [POWER_W-1:0] power_y;
      logic                      is_term;
      logic                      last;
      logic        [1:0]         status;
   } rsp_word_type;

   // shadow term table
   logic signed [COEF_W-1:0]  coef_table    [MAX_TERMS];
   logic        [POWER_W-1:0] power_x_table [MAX_TERMS];
   logic        [POWER_W-1:0] power_y_table [MAX_TERMS];
   bit                        absorbed      [MAX_TERMS];
   int                        stored_terms;
   int                        first_terms;

   rsp_word_type expected_words [$];
   rsp_word_type got;
   rsp_word_type want;
   int           mismatches;

   initial begin
      error_count       = 0;
      words_outstanding = 0;
      mismatches        = 0;
      stored_terms      = 0;
      first_terms       = 0;
   end

   function automatic bit append_term(input logic signed [COEF_W-1:0] coef,
                                      input logic [POWER_W-1:0] px,
                                      input logic [POWER_W-1:0] py);
      if (stored_terms >= MAX_TERMS) return 1'b0;
      coef_table[stored_terms]    = coef;
      power_x_table[stored_terms] = px;
      power_y_table[stored_terms] = py;
      absorbed[stored_terms]      = 1'b0;
      stored_terms++;
      return 1'b1;
   endfunction

   task automatic apply_term_request(input logic [1:0] kind,
                                     input logic signed [COEF_W-1:0] coef,
                                     input logic [POWER_W-1:0] px,
                                     input logic [POWER_W-1:0] py);
      rsp_word_type ack;
      rsp_word_type term_word;
      int           slot;
      bit           streamed;
      ack      = '0;
      ack.last = 1'b1;
      streamed = 1'b0;
      slot     = -1;
      case (kind)
         REQ_LOAD: begin
            if (append_term(coef, px, py)) first_terms = stored_terms;
            else ack.status = STAT_FULL;
         end
         REQ_ADD: begin
            // earliest first-polynomial entry that has not absorbed yet
            for (int i = 0; i < first_terms; i++)
               if (slot < 0 && !absorbed[i] && power_x_table[i] == px && power_y_table[i] == py)
                  slot = i;
            if (slot >= 0) begin
               coef_table[slot] = coef_table[slot] + coef;
               absorbed[slot]   = 1'b1;
               ack.status       = STAT_MERGED;
            end else if (!append_term(coef, px, py)) begin
               ack.status = STAT_FULL;
            end
         end
         REQ_EMIT: begin
            for (int i = 0; i < stored_terms; i++) begin
               term_word         = '0;
               term_word.coef    = coef_table[i];
               term_word.power_x = power_x_table[i];
               term_word.power_y = power_y_table[i];
               term_word.is_term = 1'b1;
               term_word.last    = (i == stored_terms - 1);
               term_word.status  = STAT_OK;
               expected_words.push_back(term_word);
               streamed = 1'b1;
            end
         end
         REQ_CLEAR: begin
            stored_terms = 0;
            first_terms  = 0;
            for (int i = 0; i < MAX_TERMS; i++) absorbed[i] = 1'b0;
         end
         default: ;
      endcase
      if (!streamed) expected_words.push_back(ack);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stored_terms = 0;
         first_terms  = 0;
         for (int i = 0; i < MAX_TERMS; i++) absorbed[i] = 1'b0;
         expected_words.delete();
      end else begin
         if (rsp_valid !== 1'b0) begin
            got = {rsp_out_coefficient, rsp_out_power_x, rsp_out_power_y,
                   rsp_is_term, rsp_last, rsp_status};
            if (expected_words.size() == 0) begin
               $display("%0t unexpected word: expected none", $time);
               $display("%0t   actual coef %h px %h py %h term %b last %b status %0d",
                        $time, got.coef, got.power_x, got.power_y, got.is_term, got.last,
                        got.status);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               if (got.coef !== want.coef || got.power_x !== want.power_x ||
                   got.power_y !== want.power_y || got.is_term !== want.is_term ||
                   got.last !== want.last || got.status !== want.status) begin
                  $display("%0t word mismatch: expected coef %h px %h py %h term %b last %b st %0d",
                           $time, want.coef, want.power_x, want.power_y, want.is_term,
                           want.last, want.status);
                  $display("%0t                  actual coef %h px %h py %h term %b last %b st %0d",
                           $time, got.coef, got.power_x, got.power_y, got.is_term, got.last,
                           got.status);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            apply_term_request(req_type, req_coefficient, req_power_x, req_power_y);
      end
      error_count       <= mismatches;
      words_outstanding <= expected_words.size();
   end

endmodule

>>> tb/sparse_poly_term_adder_core_test.sv
// stimulus, watchdog and verdict for the sparse polynomial term adder
`timescale 1ns / 1ps

module sparse_poly_term_adder_core_test;

   import spta_pkg::*;

   localparam int TABLE_DEPTH  = DEFAULT_MAX_TERMS;
   localparam int RANDOM_ITEMS = 340;
   localparam int IDLE_LIMIT   = 4000;   // cycles with no accepted word at all
   localparam int DRAIN_CYCLES = 40;     // tail after the last expected word

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       start           = 1'b0;
   logic                       busy;
   logic        [1:0]          req_type        = REQ_CLEAR;
   logic signed [COEF_W-1:0]   req_coefficient = '0;
   logic        [POWER_W-1:0]  req_power_x     = '0;
   logic        [POWER_W-1:0]  req_power_y     = '0;
   logic                       rsp_valid;
   logic signed [COEF_W-1:0]   rsp_out_coefficient;
   logic        [POWER_W-1:0]  rsp_out_power_x;
   logic        [POWER_W-1:0]  rsp_out_power_y;
   logic                       rsp_is_term;
   logic                       rsp_last;
   logic        [1:0]          rsp_status;

   int error_count;
   int words_outstanding;
   int idle_cycles = 0;
   int items_sent  = 0;
   bit gaps_on     = 1'b1;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sparse_poly_term_adder_core #(.MAX_TERMS(TABLE_DEPTH)) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_coefficient     (req_coefficient),
      .req_power_x         (req_power_x),
      .req_power_y         (req_power_y),
      .rsp_valid           (rsp_valid),
      .rsp_out_coefficient (rsp_out_coefficient),
      .rsp_out_power_x     (rsp_out_power_x),
      .rsp_out_power_y     (rsp_out_power_y),
      .rsp_is_term         (rsp_is_term),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status)
   );

   term_table_checker #(.MAX_TERMS(TABLE_DEPTH)) table_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_coefficient     (req_coefficient),
      .req_power_x         (req_power_x),
      .req_power_y         (req_power_y),
      .rsp_valid           (rsp_valid),
      .rsp_out_coefficient (rsp_out_coefficient),
      .rsp_out_power_x     (rsp_out_power_x),
      .rsp_out_power_y     (rsp_out_power_y),
      .rsp_is_term         (rsp_is_term),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .error_count         (error_count),
      .words_outstanding   (words_outstanding)
   );

   // watchdog: any accepted request or response word restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // mostly back to back, sometimes a few cycles, rarely a long pause
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(25, 70);
   endfunction

   // extremes, tiny values near zero and plain random words
   function automatic logic [COEF_W-1:0] pick_coefficient();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // random power in the full 8-bit range
   function automatic logic [POWER_W-1:0] pick_power();
      return POWER_W'($urandom_range(0, 255));
   endfunction

   // drive one request word and hold it until the core takes it
   task automatic send_word(input logic [1:0] kind, input logic [COEF_W-1:0] coef,
                            input logic [POWER_W-1:0] px, input logic [POWER_W-1:0] py);
      int gap;
      start           <= 1'b1;
      req_type        <= kind;
      req_coefficient <= coef;
      req_power_x     <= px;
      req_power_y     <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         // junk on the fields while start is low must be ignored
         start           <= 1'b0;
         req_type        <= 2'($urandom_range(0, 3));
         req_coefficient <= $urandom;
         req_power_x     <= pick_power();
         req_power_y     <= pick_power();
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the request side until every predicted word has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
   endtask

   // clear, load the first polynomial, add the second one, emit the sum
   task automatic run_poly_sum(input bit big);
      logic [POWER_W-1:0] pool_x [8];
      logic [POWER_W-1:0] pool_y [8];
      int                 keys;
      int                 loads;
      int                 adds;
      int                 k;
      keys = $urandom_range(1, 8);
      for (int i = 0; i < keys; i++) begin
         pool_x[i] = pick_power();
         pool_y[i] = pick_power();
      end
      if (big) begin
         // load near or past the table depth
         loads = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 2);
         adds  = $urandom_range(4, 10);
      end else begin
         loads = $urandom_range(0, 8);
         adds  = $urandom_range(0, 8);
      end
      // now and then skip the clear so old terms carry over
      if ($urandom_range(0, 9) != 0) send_word(REQ_CLEAR, $urandom, pick_power(), pick_power());
      for (int i = 0; i < loads; i++) begin
         k = $urandom_range(0, keys - 1);
         if ($urandom_range(0, 4) == 0) send_word(REQ_LOAD, pick_coefficient(),
                                                  pick_power(), pick_power());
         else send_word(REQ_LOAD, pick_coefficient(), pool_x[k], pool_y[k]);
      end
      for (int i = 0; i < adds; i++) begin
         k = $urandom_range(0, keys - 1);
         if ($urandom_range(0, 6) == 0) send_word(REQ_ADD, pick_coefficient(),
                                                  pick_power(), pick_power());
         else send_word(REQ_ADD, pick_coefficient(), pool_x[k], pool_y[k]);
      end
      send_word(REQ_EMIT, $urandom, pick_power(), pick_power());
   endtask

   initial begin
      int random_target;
      int burst;
      int round;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, coefficient and power extremes, merge rules
      send_word(REQ_EMIT,  32'h0000_0000, 8'd0,   8'd0);    // emit on an empty table
      send_word(REQ_CLEAR, 32'hFFFF_FFFF, 8'd255, 8'd255);  // clear on an empty table
      send_word(REQ_LOAD,  32'h7FFF_FFFF, 8'd255, 8'd255);
      send_word(REQ_LOAD,  32'h8000_0000, 8'd0,   8'd0);
      send_word(REQ_LOAD,  32'h0000_0005, 8'd255, 8'd0);
      send_word(REQ_LOAD,  32'h0000_000C, 8'd0,   8'd255);
      send_word(REQ_ADD,   32'h0000_0001, 8'd255, 8'd255);  // positive wrap on merge
      send_word(REQ_ADD,   32'h0000_0001, 8'd255, 8'd255);  // already absorbed, so appended
      send_word(REQ_ADD,   32'hFFFF_FFFB, 8'd255, 8'd0);    // zero sum is kept
      send_word(REQ_ADD,   32'h8000_0000, 8'd0,   8'd0);    // negative wrap to zero
      send_word(REQ_ADD,   32'h0000_0003, 8'd17,  8'd42);   // no match, appended
      send_word(REQ_ADD,   32'h0000_0004, 8'd17,  8'd42);   // appended term is no target
      send_word(REQ_EMIT,  32'h0000_0000, 8'd0,   8'd0);
      send_word(REQ_LOAD,  32'h0000_0009, 8'd17,  8'd42);   // load after adds
      send_word(REQ_ADD,   32'hFFFF_FFFD, 8'd17,  8'd42);   // now hits the first appended one
      send_word(REQ_ADD,   32'hFFFF_FFFF, 8'd255, 8'd255);
      send_word(REQ_EMIT,  32'h0000_0000, 8'd0,   8'd0);
      send_word(REQ_CLEAR, 32'h0000_0000, 8'd0,   8'd0);
      send_word(REQ_EMIT,  32'h0000_0000, 8'd0,   8'd0);
      send_word(REQ_ADD,   32'hAAAA_AAAA, 8'h55,  8'hAA);   // add with no first polynomial
      send_word(REQ_ADD,   32'h5555_5555, 8'h55,  8'hAA);
      send_word(REQ_EMIT,  32'h0000_0000, 8'd0,   8'd0);
      wait_drained();

      // random: mostly well formed sums, some noise, a full table now and then
      random_target = items_sent + RANDOM_ITEMS;
      round = 0;
      while (items_sent < random_target) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 6);
            for (int i = 0; i < burst; i++)
               send_word(2'($urandom_range(0, 3)), pick_coefficient(),
                         pick_power(), pick_power());
         end else begin
            run_poly_sum(round % 7 == 3);
         end
         if ($urandom_range(0, 4) == 0) wait_drained();
         round++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && words_outstanding == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/spta_pkg.sv
rtl/spta_ram.sv
rtl/spta_match.sv
rtl/sparse_poly_term_adder_core.sv
tb/term_table_checker.sv
tb/sparse_poly_term_adder_core_test.sv
